/* sv/lrs_pkg.sv */
// Package for the Liouville running-sum block.
// Holds widths, constants and the request/response types of the shared divider.
`timescale 1ns / 1ps

package lrs_pkg;

  // Width of the input integer.
  localparam int NUMBER_BITS = 24;
  // Width of the saturating running sum.
  localparam int SUM_BITS = 32;
  // Width of the factor count result.
  localparam int COUNT_BITS = 5;
  // Trial divisors run up to just past the square root of the largest input.
  localparam int DIV_BITS = (NUMBER_BITS + 1) / 2 + 1;
  // Width of a squared trial divisor.
  localparam int SQ_BITS = 2 * DIV_BITS;
  // Width of the divider's step counter.
  localparam int STEP_BITS = $clog2(NUMBER_BITS);

  // Trial division starts at the smallest prime.
  localparam logic [DIV_BITS-1:0] FIRST_DIVISOR = DIV_BITS'(2);

  // Saturation limits of the running sum.
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS - 1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS - 1){1'b0}}};

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic                   start;
    logic [NUMBER_BITS-1:0] dividend;
    logic [DIV_BITS-1:0]    divisor;
  } div_req_t;

  // Response from the divider to the sequencer.
  typedef struct packed {
    logic                   done;
    logic [NUMBER_BITS-1:0] quotient;
    logic [DIV_BITS-1:0]    remainder;
  } div_rsp_t;

endpackage

/* sv/lrs_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on lrs_pkg for widths and the request/response types.
`timescale 1ns / 1ps

module lrs_div (
  input  logic             clk,
  input  logic             rst,
  input  lrs_pkg::div_req_t req,
  output lrs_pkg::div_rsp_t rsp
);

  logic                                busy;
  logic                                done;
  logic [lrs_pkg::STEP_BITS-1:0]       step;
  logic [lrs_pkg::DIV_BITS-1:0]        rem;
  logic [lrs_pkg::NUMBER_BITS-1:0]     quo;
  logic [lrs_pkg::DIV_BITS-1:0]        divisor;
  logic [lrs_pkg::DIV_BITS:0]          trial;
  logic [lrs_pkg::DIV_BITS:0]          diff;
  logic                                fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem, quo[lrs_pkg::NUMBER_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  // Control: busy while the NUMBER_BITS quotient bits are formed, then a one-cycle done flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        step <= lrs_pkg::STEP_BITS'(lrs_pkg::NUMBER_BITS - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
          step <= step - 1'b1;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  // Datapath: the quotient bits shift in where the dividend bits shift out.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[lrs_pkg::DIV_BITS-1:0];
      end else begin
        rem <= trial[lrs_pkg::DIV_BITS-1:0];
      end
      quo <= {quo[lrs_pkg::NUMBER_BITS-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

/* sv/liouville_running_sum.sv */
// Top level of the Liouville running-sum block: trial-division sequencer and sum.
// Depends on lrs_pkg and instantiates the shared divider lrs_div.
`timescale 1ns / 1ps

// Each transaction on the input carries one integer; the block factors it by
// trial division, counts its prime factors with multiplicity, and returns one
// result transaction with that count, the sign of the Liouville value (set when
// the count is odd) and the saturating running sum of those values since reset.
// One item is worked at a time and in_stall is high until the sequencer is idle.
// Each trial divisor costs one compare in the check state (divisor squared
// against the cofactor, on a single multiplier) and every division a further
// pass through the shared bit-serial divider, so the time for an item grows with
// its number of divisions and is longest for a 24-bit prime near the top of the range.
// The input is taken again while a finished result still waits on out_stall.
module liouville_running_sum (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [lrs_pkg::NUMBER_BITS-1:0]       number,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [lrs_pkg::COUNT_BITS-1:0]        factor_count,
  output logic                                  lambda_negative,
  output logic signed [lrs_pkg::SUM_BITS-1:0]   running_sum
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_DIVIDE = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]                        state;
  logic [lrs_pkg::NUMBER_BITS-1:0]   rest;
  logic [lrs_pkg::DIV_BITS-1:0]      divisor;
  logic [lrs_pkg::COUNT_BITS-1:0]    count;
  logic signed [lrs_pkg::SUM_BITS-1:0] total;
  logic [lrs_pkg::SQ_BITS-1:0]       div_sq;
  logic [lrs_pkg::SQ_BITS-1:0]       rest_ext;
  logic                              past_root;
  logic                              out_free;
  lrs_pkg::div_req_t                 div_req;
  lrs_pkg::div_rsp_t                 div_rsp;

  // The loop ends once the divisor squared exceeds the cofactor.
  assign div_sq    = lrs_pkg::SQ_BITS'(divisor) * lrs_pkg::SQ_BITS'(divisor);
  assign rest_ext  = lrs_pkg::SQ_BITS'(rest);
  assign past_root = div_sq > rest_ext;

  // The output register is free when empty or being taken this cycle.
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != ST_IDLE);

  // Start a division from the check state whenever the current divisor is still in range.
  assign div_req.start    = (state == ST_CHECK) && !past_root;
  assign div_req.dividend = rest;
  assign div_req.divisor  = divisor;

  lrs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      total     <= '0;
    end else begin
      // The result register fills from the done state and empties when taken.
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (past_root) begin
            state <= ST_DONE;
          end else begin
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_rsp.done) begin
            state <= ST_CHECK;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
            // Saturating update: odd count subtracts one, even count adds one.
            if (count[0]) begin
              if (total != lrs_pkg::SUM_MIN) begin
                total <= total - lrs_pkg::SUM_BITS'(1);
              end
            end else begin
              if (total != lrs_pkg::SUM_MAX) begin
                total <= total + lrs_pkg::SUM_BITS'(1);
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Working registers of the trial division and the result fields.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          rest    <= number;
          divisor <= lrs_pkg::FIRST_DIVISOR;
          count   <= '0;
        end
      end
      ST_CHECK: begin
        // A cofactor above one left at the end is one more prime factor.
        if (past_root && (rest > lrs_pkg::NUMBER_BITS'(1))) begin
          count <= count + 1'b1;
        end
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            count <= count + 1'b1;
            rest  <= div_rsp.quotient;
          end else begin
            divisor <= divisor + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          factor_count    <= count;
          lambda_negative <= count[0];
        end
      end
      default: begin
      end
    endcase
  end

  assign running_sum = total;

endmodule

/* tb/tb.sv */
// Self-checking testbench for liouville_running_sum: directed and random integers,
// with a built-in prime-factor predictor and random idling on both channels.
// Depends on lrs_pkg and the liouville_running_sum RTL.
`timescale 1ns / 1ps

module tb;

  // One expected result transaction.
  typedef struct packed {
    logic [lrs_pkg::COUNT_BITS-1:0]      count;
    logic                                negative;
    logic signed [lrs_pkg::SUM_BITS-1:0] sum;
  } liouville_result_t;

  // Trial-division work allowed for one random item, in divisions.
  localparam int unsigned TRIAL_BUDGET = 400;
  localparam int unsigned RANDOM_ITEMS = 120;

  logic                                   clk = 1'b0;
  logic                                   rst = 1'b1;
  logic                                   in_valid = 1'b0;
  logic                                   in_stall;
  logic [lrs_pkg::NUMBER_BITS-1:0]        number = '0;
  logic                                   out_valid;
  logic                                   out_stall = 1'b0;
  logic [lrs_pkg::COUNT_BITS-1:0]         factor_count;
  logic                                   lambda_negative;
  logic signed [lrs_pkg::SUM_BITS-1:0]    running_sum;

  logic [lrs_pkg::NUMBER_BITS-1:0]        pending_numbers[$];
  liouville_result_t                      expected_results[$];
  logic signed [lrs_pkg::SUM_BITS-1:0]    liouville_sum = '0;
  logic                                   in_taken = 1'b0;
  int unsigned                            error_count = 0;
  int unsigned                            feed_gap = 0;
  int unsigned                            stall_left = 0;
  bit                                     feed_calm = 1'b0;
  bit                                     drain_calm = 1'b0;

  liouville_running_sum uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .number          (number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .factor_count    (factor_count),
    .lambda_negative (lambda_negative),
    .running_sum     (running_sum)
  );

  // 50 MHz clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Counts prime factors with multiplicity by trial division. The number of
  // divisions spent is returned too, so the stimulus can bound the block's work.
  function automatic int unsigned omega(input longint unsigned value,
                                        output int unsigned trials);
    longint unsigned rest;
    longint unsigned divisor;
    int unsigned     count;
    rest = value;
    count = 0;
    trials = 0;
    for (divisor = 2; divisor * divisor <= rest; divisor++) begin
      trials++;
      while (rest % divisor == 0) begin
        count++;
        trials++;
        rest = rest / divisor;
      end
    end
    if (rest > 1) begin
      count++;
    end
    return count;
  endfunction

  // Idle length: mostly short, sometimes medium, rarely long.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      return $urandom_range(0, 2);
    end else if (pick < 92) begin
      return $urandom_range(3, 12);
    end
    return $urandom_range(20, 150);
  endfunction

  // Input driver: presents the next number at the falling edge once the
  // previous transaction went through and the chosen gap has elapsed.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (feed_gap != 0) begin
        in_valid <= 1'b0;
        feed_gap--;
      end else if (pending_numbers.size() != 0) begin
        in_valid <= 1'b1;
        number <= pending_numbers.pop_front();
        if ($urandom_range(0, 24) == 0) begin
          feed_calm = !feed_calm;
        end
        feed_gap = feed_calm ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure: random stall bursts, with calm stretches between.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 24) == 0) begin
        drain_calm = !drain_calm;
      end
      stall_left = drain_calm ? 0 : idle_len();
    end
  end

  // Scoreboard: checks each result transaction against the oldest prediction,
  // and predicts the result of each accepted number.
  always @(posedge clk) begin : check_results
    liouville_result_t want;
    int unsigned       count;
    int unsigned       trials;
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no number pending: factor_count %0d, sum %0d",
               factor_count, running_sum);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (factor_count !== want.count) begin
          $error("factor_count: expected %0d, actual %0d", want.count, factor_count);
          error_count++;
        end
        if (lambda_negative !== want.negative) begin
          $error("lambda_negative: expected %0d, actual %0d", want.negative,
                 lambda_negative);
          error_count++;
        end
        if (running_sum !== want.sum) begin
          $error("running_sum: expected %0d, actual %0d", want.sum, running_sum);
          error_count++;
        end
      end
    end
    if (!rst && in_valid && !in_stall) begin
      count = omega(number, trials);
      want.count = count[lrs_pkg::COUNT_BITS-1:0];
      want.negative = count[0];
      // The sum saturates instead of wrapping.
      if (want.negative) begin
        if (liouville_sum != lrs_pkg::SUM_MIN) begin
          liouville_sum = liouville_sum - 1;
        end
      end else if (liouville_sum != lrs_pkg::SUM_MAX) begin
        liouville_sum = liouville_sum + 1;
      end
      want.sum = liouville_sum;
      expected_results.push_back(want);
    end
  end

  // Stimulus, reset and end of test.
  initial begin : stimulus
    int unsigned     directed_numbers[] = '{
      0, 1, 2, 3, 4, 6, 30, 210, 49, 97, 1024, 65536, 65521,
      16777215, 8388608, 12582912, 8388607, 11184810, 5592405,
      16777213, 16752649, 9699690, 510510
    };
    int unsigned     smooth_primes[8] = '{2, 3, 5, 7, 11, 13, 17, 19};
    longint unsigned top_value;
    longint unsigned candidate;
    int unsigned     steps;
    int unsigned     prime;
    int unsigned     width;
    int unsigned     trials;
    top_value = (longint'(1) << lrs_pkg::NUMBER_BITS) - 1;

    // Directed part: zero and one, the all-ones input, high powers of two,
    // large primes and a square of a large prime (the slowest inputs), and
    // numbers with many distinct small factors.
    foreach (directed_numbers[i]) begin
      pending_numbers.push_back(directed_numbers[i][lrs_pkg::NUMBER_BITS-1:0]);
    end

    // Random part: smooth numbers reach high bits with many factors; plain
    // random values of random width cover the rest. Costly factorizations
    // are redrawn so the run stays short.
    repeat (RANDOM_ITEMS) begin
      do begin
        if ($urandom_range(0, 9) < 4) begin
          candidate = 1;
          steps = $urandom_range(1, 28);
          repeat (steps) begin
            prime = smooth_primes[$urandom_range(0, 7)];
            if (candidate * prime <= top_value) begin
              candidate = candidate * prime;
            end
          end
        end else begin
          width = ($urandom_range(0, 3) == 0) ? $urandom_range(13, lrs_pkg::NUMBER_BITS)
                                              : $urandom_range(1, 12);
          candidate = longint'($urandom) & ((longint'(1) << width) - 1);
        end
        void'(omega(candidate, trials));
      end while (trials > TRIAL_BUDGET);
      pending_numbers.push_back(candidate[lrs_pkg::NUMBER_BITS-1:0]);
    end

    // Hold reset, then release it at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every number to be taken and every result to come back.
    while (pending_numbers.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #200_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
